// File: rtl/rmc_pkg.sv
// ----------------------------------------------------------------------------
// rmc_pkg: shared types and constants for the RSA modexp character cipher
// Register indexes, widths, controller states and the control/status
// structs between controller and datapath.
// ----------------------------------------------------------------------------
package rmc_pkg;

    localparam int WORD_BITS_DEF = 64;   // default arithmetic width
    localparam int DATA_BITS     = 64;   // width of data, value and config data
    localparam int CHAR_BITS     = 8;
    localparam int CFG_IDX_BITS  = 2;

    localparam logic [CHAR_BITS-1:0] CHAR_BASE = 8'd97;  // 'a'

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_EXPONENT = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MODULUS  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DECRYPT  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_FIX,
        ST_EXP,
        ST_MUL,
        ST_MADD,
        ST_MWB,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        DP_NOP,
        DP_LOAD,     // capture input, start reduction of base
        DP_RED,      // one remainder step
        DP_FIX,      // wrap negative offset, init accumulator and exponent
        DP_MSTART,   // start a modular product
        DP_DBL,      // product = 2*product mod m
        DP_ADD,      // product = product + multiplicand mod m
        DP_WB        // write product back
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   sq;      // product is base*base (else acc*base)
        logic   shift;   // advance multiplier bit on a doubling step
    } t_dp_cmd;

    typedef struct packed {
        logic m_small;     // modulus below 2
        logic cnt_last;    // last bit step of reduction or product
        logic mplier_msb;  // current multiplier bit
        logic ecnt_zero;   // all exponent bits done
        logic exp_lsb;     // current exponent bit
    } t_dp_sts;

endpackage

// File: rtl/rmc_cfg_if.sv
// ----------------------------------------------------------------------------
// rmc_cfg_if: configuration write channel
// Register index plus write data, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rmc_cfg_if import rmc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_BITS-1:0] index;
    logic [DATA_BITS-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/rmc_in_if.sv
// ----------------------------------------------------------------------------
// rmc_in_if: input word channel
// One character or ciphertext word per handshake.
// ----------------------------------------------------------------------------
interface rmc_in_if import rmc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [DATA_BITS-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// File: rtl/rmc_out_if.sv
// ----------------------------------------------------------------------------
// rmc_out_if: result word channel
// Exponentiation result, recovered character and error flag.
// ----------------------------------------------------------------------------
interface rmc_out_if import rmc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [DATA_BITS-1:0] value;
    logic [CHAR_BITS-1:0] plain_char;
    logic                 error;

    modport source (output valid, value, plain_char, error, input ready);
    modport sink   (input valid, value, plain_char, error, output ready);
endinterface

// File: rtl/rsa_modexp_char_cipher_unit.sv
// ----------------------------------------------------------------------------
// A modulus below 2 skips the arithmetic: the controller goes from idle to done
// and loads the error word into the output register. Otherwise the base is
// reduced one remainder step per bit, then per exponent bit it is squared after,
// on a set bit, the product with the result, all on the add-mod unit.
// Throughput: one word in work; the next is taken while the last result waits.
// Reset (synchronous, active low) clears config, state machine and output valid.
// ----------------------------------------------------------------------------
// rsa_modexp_char_cipher_unit: RSA modular exponentiation character cipher
// Computes base^exponent mod modulus. Encrypt: base is the input byte minus
// 'a' wrapped into [0, modulus). Decrypt: base is the input mod modulus, and
// the recovered character ('a' + value) mod 256 is reported too.
// ----------------------------------------------------------------------------
module rsa_modexp_char_cipher_unit import rmc_pkg::*; #(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    rmc_cfg_if.sink   i_cfg,
    rmc_in_if.sink    i_in,
    rmc_out_if.source o_out
);

    // ---------------- configuration registers ----------------
    logic [WORD_BITS-1:0] r_exponent, r_modulus;
    logic                 r_decrypt;

    assign i_cfg.ready = 1'b1;  // always ready; a write takes effect at the next clock edge

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exponent <= '0;
            r_modulus  <= '0;
            r_decrypt  <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_EXPONENT: r_exponent <= i_cfg.data[WORD_BITS-1:0];
                CFG_MODULUS:  r_modulus  <= i_cfg.data[WORD_BITS-1:0];
                CFG_DECRYPT:  r_decrypt  <= i_cfg.data[0];
                default: ;    // unused index, write dropped
            endcase
        end
    end

    // ---------------- controller and datapath ----------------
    t_dp_cmd              dp_cmd;
    t_dp_sts              dp_sts;
    logic [WORD_BITS-1:0] dp_value;
    logic [CHAR_BITS-1:0] dp_char;
    logic                 dp_error;
    logic                 out_load, out_free;

    // output register
    // Decouples the result word from the next item's work.
    logic                 r_out_valid;
    logic [DATA_BITS-1:0] r_out_value;
    logic [CHAR_BITS-1:0] r_out_char;
    logic                 r_out_error;

    // output register is free when empty or being drained this cycle
    assign out_free = !r_out_valid || o_out.ready;

    rmc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (dp_sts),
        .i_out_free (out_free),
        .o_cmd      (dp_cmd),
        .o_out_load (out_load)
    );

    rmc_datapath #(
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .i_data       (i_in.data),
        .i_exponent   (r_exponent),
        .i_modulus    (r_modulus),
        .i_decrypt    (r_decrypt),
        .o_sts        (dp_sts),
        .o_value      (dp_value),
        .o_plain_char (dp_char),
        .o_error      (dp_error)
    );

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_value <= DATA_BITS'(dp_value);
            r_out_char  <= dp_char;
            r_out_error <= dp_error;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.value      = r_out_value;
    assign o_out.plain_char = r_out_char;
    assign o_out.error      = r_out_error;

endmodule

// File: rtl/rmc_datapath.sv
// ----------------------------------------------------------------------------
// rmc_datapath: modular arithmetic datapath
// One shared add-mod unit (add, compare, subtract) used for base reduction,
// product doubling and product accumulation; base, accumulator, product and
// exponent registers.
// ----------------------------------------------------------------------------
module rmc_datapath import rmc_pkg::*; #(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    input  logic [DATA_BITS-1:0] i_data,
    input  logic [WORD_BITS-1:0] i_exponent,
    input  logic [WORD_BITS-1:0] i_modulus,
    input  logic                 i_decrypt,
    output t_dp_sts              o_sts,
    output logic [WORD_BITS-1:0] o_value,
    output logic [CHAR_BITS-1:0] o_plain_char,
    output logic                 o_error
);

    localparam int CW = $clog2(WORD_BITS + 1);

    logic [WORD_BITS-1:0] r_base, r_acc, r_prod, r_mcand, r_mplier, r_exp;
    logic [CW-1:0]        r_cnt, r_ecnt;
    logic                 r_neg, r_err;

    // add-mod unit: (op1 + op2 + cin) mod m, inputs below m
    logic [WORD_BITS-1:0] op1, op2, madd_res;
    logic                 cin;
    logic [WORD_BITS:0]   sum;
    logic [WORD_BITS+1:0] diff;

    always_comb begin
        op1 = r_prod;
        op2 = r_prod;
        cin = 1'b0;
        case (i_cmd.op)
            DP_RED: cin = r_mplier[WORD_BITS-1];
            DP_ADD: op2 = r_mcand;
            default: ;
        endcase
    end

    assign sum      = {1'b0, op1} + {1'b0, op2} + {{WORD_BITS{1'b0}}, cin};
    assign diff     = {1'b0, sum} - {2'b00, i_modulus};
    assign madd_res = diff[WORD_BITS+1] ? sum[WORD_BITS-1:0] : diff[WORD_BITS-1:0];

    // character offset from 'a', as magnitude and sign
    logic [CHAR_BITS-1:0] ch, mag;
    logic                 ch_ge;
    logic [WORD_BITS-1:0] red_src;

    assign ch      = i_data[CHAR_BITS-1:0];
    assign ch_ge   = (ch >= CHAR_BASE);
    assign mag     = ch_ge ? (ch - CHAR_BASE) : (CHAR_BASE - ch);
    assign red_src = i_decrypt ? i_data[WORD_BITS-1:0] : WORD_BITS'(mag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_ecnt <= '0;
            r_err  <= 1'b0;
        end else begin
            unique case (i_cmd.op)
                DP_NOP: ;
                DP_LOAD: begin
                    r_prod   <= '0;
                    r_mplier <= red_src;
                    r_cnt    <= CW'(WORD_BITS);
                    r_neg    <= !i_decrypt && !ch_ge;
                    r_err    <= o_sts.m_small;
                end
                DP_RED: begin
                    r_prod   <= madd_res;
                    r_mplier <= r_mplier << 1;
                    r_cnt    <= r_cnt - CW'(1);
                end
                DP_FIX: begin
                    r_base <= (r_neg && (r_prod != '0)) ? (i_modulus - r_prod) : r_prod;
                    r_acc  <= WORD_BITS'(1);
                    r_exp  <= i_exponent;
                    r_ecnt <= CW'(WORD_BITS);
                end
                DP_MSTART: begin
                    r_mcand  <= i_cmd.sq ? r_base : r_acc;
                    r_mplier <= r_base;
                    r_prod   <= '0;
                    r_cnt    <= CW'(WORD_BITS);
                end
                DP_DBL: begin
                    r_prod <= madd_res;
                    if (i_cmd.shift) begin
                        r_mplier <= r_mplier << 1;
                        r_cnt    <= r_cnt - CW'(1);
                    end
                end
                DP_ADD: begin
                    r_prod   <= madd_res;
                    r_mplier <= r_mplier << 1;
                    r_cnt    <= r_cnt - CW'(1);
                end
                DP_WB: begin
                    if (i_cmd.sq) begin
                        r_base <= r_prod;
                        r_exp  <= r_exp >> 1;
                        r_ecnt <= r_ecnt - CW'(1);
                    end else begin
                        // accumulator done, squaring of the base follows at once
                        r_acc    <= r_prod;
                        r_mcand  <= r_base;
                        r_mplier <= r_base;
                        r_prod   <= '0;
                        r_cnt    <= CW'(WORD_BITS);
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_sts.m_small    = (i_modulus[WORD_BITS-1:1] == '0);
    assign o_sts.cnt_last   = (r_cnt == CW'(1));
    assign o_sts.mplier_msb = r_mplier[WORD_BITS-1];
    assign o_sts.ecnt_zero  = (r_ecnt == '0);
    assign o_sts.exp_lsb    = r_exp[0];

    assign o_error      = r_err;
    assign o_value      = r_err ? '0 : r_acc;
    assign o_plain_char = (i_decrypt && !r_err) ? (CHAR_BASE + r_acc[CHAR_BITS-1:0]) : '0;

endmodule

// File: rtl/rmc_ctrl.sv
// ----------------------------------------------------------------------------
// rmc_ctrl: sequencer for reduction and square-and-multiply
// Walks exponent bits LSB first; each modular product scans the multiplier
// MSB first with a doubling step and, on set bits, an add step.
// ----------------------------------------------------------------------------
module rmc_ctrl import rmc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    input  logic    i_out_free,
    output t_dp_cmd o_cmd,
    output logic    o_out_load
);

    t_state r_state, n_state;
    logic   r_sq, n_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_sq    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sq    <= n_sq;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_sq        = r_sq;
        o_cmd.op    = DP_NOP;
        o_cmd.sq    = r_sq;
        o_cmd.shift = 1'b0;
        o_in_ready  = 1'b0;
        o_out_load  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = DP_LOAD;
                    n_state  = i_sts.m_small ? ST_DONE : ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                o_cmd.op = DP_RED;
                if (i_sts.cnt_last) begin
                    n_state = ST_FIX;
                end
            end
            ST_FIX: begin
                o_cmd.op = DP_FIX;
                n_state  = ST_EXP;
            end
            ST_EXP: begin
                if (i_sts.ecnt_zero) begin
                    n_state = ST_DONE;
                end else begin
                    // set bit: acc*base first, then base*base
                    o_cmd.op = DP_MSTART;
                    o_cmd.sq = !i_sts.exp_lsb;
                    n_sq     = !i_sts.exp_lsb;
                    n_state  = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.op    = DP_DBL;
                o_cmd.shift = !i_sts.mplier_msb;
                if (i_sts.mplier_msb) begin
                    n_state = ST_MADD;
                end else if (i_sts.cnt_last) begin
                    n_state = ST_MWB;
                end
            end
            ST_MADD: begin
                o_cmd.op = DP_ADD;
                n_state  = i_sts.cnt_last ? ST_MWB : ST_MUL;
            end
            ST_MWB: begin
                o_cmd.op = DP_WB;
                if (r_sq) begin
                    n_state = ST_EXP;
                    n_sq    = 1'b0;
                end else begin
                    n_state = ST_MUL;
                    n_sq    = 1'b1;
                end
            end
            ST_DONE: begin
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// File: rtl/rmc_checker.sv
// ----------------------------------------------------------------------------
// rmc_checker: port-level checks for the RSA modexp character cipher
// Tracks decrypt mode and words in flight from the ports and checks
// result words against them.
// ----------------------------------------------------------------------------
module rmc_checker import rmc_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_cfg_valid,
    input logic                    i_cfg_ready,
    input logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input logic [DATA_BITS-1:0]    i_cfg_data,
    input logic                    i_in_valid,
    input logic                    i_in_ready,
    input logic                    i_out_valid,
    input logic                    i_out_ready,
    input logic [DATA_BITS-1:0]    i_out_value,
    input logic [CHAR_BITS-1:0]    i_out_char,
    input logic                    i_out_error
);

    logic       r_mode;
    logic [1:0] r_cnt;
    logic       in_acc, out_acc;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_cfg_valid && i_cfg_ready && (i_cfg_index == CFG_DECRYPT)) begin
                r_mode <= i_cfg_data[0];
            end
            r_cnt <= r_cnt + {1'b0, in_acc} - {1'b0, out_acc};
        end
    end

    // result word holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_value))
        else $error("result word changed while stalled");

    // no result word right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // error words carry zeros
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_error |-> (i_out_value == '0) && (i_out_char == '0))
        else $error("error word with nonzero payload");

    // character field follows the mode and the value
    a_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_error |->
            (r_mode ? (i_out_char == CHAR_BASE + i_out_value[CHAR_BITS-1:0])
                    : (i_out_char == '0)))
        else $error("plain_char does not match value and mode");

    // one word in work plus one waiting at most
    a_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("too many words in flight");

endmodule

bind rsa_modexp_char_cipher_unit rmc_checker u_rmc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_valid (i_cfg.valid),
    .i_cfg_ready (i_cfg.ready),
    .i_cfg_index (i_cfg.index),
    .i_cfg_data  (i_cfg.data),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_value (o_out.value),
    .i_out_char  (o_out.plain_char),
    .i_out_error (o_out.error)
);

// File: sim/rsa_modexp_char_cipher_unit_tb.sv
// ----------------------------------------------------------------------------
// rsa_modexp_char_cipher_unit_tb: self-checking bench for the RSA modexp unit
// Programs exponent, modulus and mode through the config channel, feeds
// characters and ciphertext words, and checks every result word against a
// behavioral modexp predictor built on wide multiply and remainder. A short
// directed table covers the reset key, small moduli, zero exponents, byte wrap and
// oversize ciphertext. Key phases with random stimulus follow. Both handshake
// sides stall at random.
// ----------------------------------------------------------------------------
module rsa_modexp_char_cipher_unit_tb import rmc_pkg::*; ();

    localparam logic [DATA_BITS-1:0] WMAX = {DATA_BITS{1'b1}};
    localparam int RAND_WORDS = 80;

    // one expected result word
    typedef struct packed {
        logic [DATA_BITS-1:0] value;
        logic [CHAR_BITS-1:0] pchar;
        logic                 err;
    } t_cipher_word;

    // directed row: key setting, input word, and an optional typed-in result
    typedef struct packed {
        logic [DATA_BITS-1:0] exp_v;
        logic [DATA_BITS-1:0] mod_v;
        logic                 dec;
        logic [DATA_BITS-1:0] data;
        logic                 typed;
        logic [DATA_BITS-1:0] t_value;
        logic [CHAR_BITS-1:0] t_char;
        logic                 t_err;
    } t_key_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rmc_cfg_if cfg_if();
    rmc_in_if  word_in();
    rmc_out_if word_out();

    rsa_modexp_char_cipher_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (word_in),
        .o_out   (word_out)
    );

    always #4 i_clk = ~i_clk;

    // bench copy of the key registers, tracked at each config handshake
    logic [DATA_BITS-1:0] key_exp  = '0;
    logic [DATA_BITS-1:0] key_mod  = '0;
    logic                 dec_mode = 1'b0;

    t_cipher_word cipher_due[$];   // results owed by the DUT, oldest first
    t_cipher_word due_head;
    int           mismatches = 0;
    bit           calm = 1'b0;     // phase with no sender gaps

    // Directed table. Rows with typed = 1 carry a result that is obvious:
    // error words, zero exponent, zero base. The rest go through the predictor.
    t_key_row key_rows [0:19] = '{
        // after reset: modulus still 0, error word
        '{64'd0, 64'd0, 1'b0, 64'h0123_4567_89AB_CDEF, 1'b1, 64'd0, 8'd0, 1'b1},
        // modulus 1, both modes
        '{64'd5, 64'd1, 1'b0, 64'h61, 1'b1, 64'd0, 8'd0, 1'b1},
        '{64'd5, 64'd1, 1'b1, WMAX, 1'b1, 64'd0, 8'd0, 1'b1},
        // modulus 0 in decrypt mode
        '{64'd0, 64'd0, 1'b1, 64'h7A, 1'b1, 64'd0, 8'd0, 1'b1},
        // zero exponent gives 1; decrypt also reports 'b'
        '{64'd0, WMAX, 1'b0, 64'h61, 1'b1, 64'd1, 8'd0, 1'b0},
        '{64'd0, WMAX, 1'b1, WMAX, 1'b1, 64'd1, 8'h62, 1'b0},
        // 'a' maps to base 0
        '{64'd1, WMAX, 1'b0, 64'h61, 1'b1, 64'd0, 8'd0, 1'b0},
        // bytes below 'a' wrap, high bytes stay unsigned
        '{64'd1, WMAX, 1'b0, 64'h00, 1'b0, 64'd0, 8'd0, 1'b0},
        '{64'd1, WMAX, 1'b0, 64'hFF, 1'b0, 64'd0, 8'd0, 1'b0},
        // upper data bits ignored in encrypt mode
        '{64'd1, WMAX, 1'b0, 64'hFFFF_FFFF_FFFF_FF61, 1'b1, 64'd0, 8'd0, 1'b0},
        '{WMAX, WMAX, 1'b0, 64'h7A, 1'b0, 64'd0, 8'd0, 1'b0},
        // textbook key pair, 61 * 53
        '{64'd65537, 64'd3233, 1'b0, 64'h68, 1'b0, 64'd0, 8'd0, 1'b0},
        '{64'd65537, 64'd3233, 1'b0, 64'h20, 1'b0, 64'd0, 8'd0, 1'b0},
        '{64'd2753, 64'd3233, 1'b1, 64'd855, 1'b0, 64'd0, 8'd0, 1'b0},
        // ciphertext above the modulus is reduced first
        '{64'd2753, 64'd3233, 1'b1, WMAX, 1'b0, 64'd0, 8'd0, 1'b0},
        // smallest legal modulus
        '{WMAX, 64'd2, 1'b1, WMAX, 1'b0, 64'd0, 8'd0, 1'b0},
        '{64'd3, 64'd2, 1'b0, 64'h00, 1'b0, 64'd0, 8'd0, 1'b0},
        // offset a multiple of the modulus: wrapped base is 0
        '{64'd7, 64'd97, 1'b0, 64'h00, 1'b0, 64'd0, 8'd0, 1'b0},
        '{64'hD6F4_1A3C_9E27_5B81, 64'hFFFF_FFFF_FFFF_FFC5, 1'b1,
          64'hFFFF_FFFF_FFFF_FFC4, 1'b0, 64'd0, 8'd0, 1'b0},
        '{64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001, 1'b0,
          64'h80, 1'b0, 64'd0, 8'd0, 1'b0}
    };

    // a*b mod m through a full 128-bit product
    function automatic logic [DATA_BITS-1:0] mul_mod_wide(
        input logic [DATA_BITS-1:0] a,
        input logic [DATA_BITS-1:0] b,
        input logic [DATA_BITS-1:0] m
    );
        logic [2*DATA_BITS-1:0] prod;
        prod = {{DATA_BITS{1'b0}}, a} * {{DATA_BITS{1'b0}}, b};
        prod = prod % {{DATA_BITS{1'b0}}, m};
        return prod[DATA_BITS-1:0];
    endfunction

    // result word for one input word under the current key setting
    function automatic t_cipher_word predict_cipher(input logic [DATA_BITS-1:0] data);
        t_cipher_word         w;
        logic [DATA_BITS-1:0] base;
        logic [DATA_BITS-1:0] rem;
        logic [DATA_BITS-1:0] acc;
        logic [DATA_BITS-1:0] offs;
        logic [CHAR_BITS-1:0] ch;
        w = '0;
        if (key_mod < 2) begin
            w.err = 1'b1;
            return w;
        end
        if (dec_mode) begin
            base = data % key_mod;
        end else begin
            ch = data[CHAR_BITS-1:0];
            if (ch >= CHAR_BASE) begin
                offs = {56'd0, ch - CHAR_BASE};
                base = offs % key_mod;
            end else begin
                // negative offset: wrap into [0, modulus)
                offs = {56'd0, CHAR_BASE - ch};
                rem  = offs % key_mod;
                base = (rem != 0) ? key_mod - rem : '0;
            end
        end
        acc = 64'd1;
        for (int i = 0; i < DATA_BITS; i++) begin
            if (key_exp[i])
                acc = mul_mod_wide(acc, base, key_mod);
            base = mul_mod_wide(base, base, key_mod);
        end
        w.value = acc;
        if (dec_mode)
            w.pchar = CHAR_BASE + acc[CHAR_BITS-1:0];
        return w;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 20);
        return $urandom_range(50, 300);
    endfunction

    task automatic write_key_reg(input logic [CFG_IDX_BITS-1:0] idx,
                                 input logic [DATA_BITS-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        case (idx)
            CFG_EXPONENT: key_exp  = val;
            CFG_MODULUS:  key_mod  = val;
            CFG_DECRYPT:  dec_mode = val[0];
            default: ;
        endcase
    endtask

    // full key load; only called with nothing in flight
    task automatic load_key(input logic [DATA_BITS-1:0] e,
                            input logic [DATA_BITS-1:0] m,
                            input logic dec);
        write_key_reg(CFG_EXPONENT, e);
        write_key_reg(CFG_MODULUS, m);
        write_key_reg(CFG_DECRYPT, {63'd0, dec});
        cfg_if.valid <= 1'b0;
    endtask

    // drop valid and hold until every owed word has come back
    task automatic wait_drained();
        word_in.valid <= 1'b0;
        do @(posedge i_clk); while (cipher_due.size() != 0);
    endtask

    // send one word after an optional gap; valid stays up after acceptance
    // so back-to-back words need no low cycle
    task automatic send_word(input logic [DATA_BITS-1:0] d, input int gap,
                             input t_cipher_word want);
        if (gap > 0) begin
            word_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        word_in.valid <= 1'b1;
        word_in.data  <= d;
        do @(posedge i_clk); while (!word_in.ready);
        cipher_due.push_back(want);
    endtask

    // ------------------------------------------------------------------
    // Result sink: random backpressure, with long ready runs in between
    // ------------------------------------------------------------------
    initial begin
        int n;
        word_out.ready <= 1'b0;
        forever begin
            n = idle_len();
            if (n > 0) begin
                word_out.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            word_out.ready <= 1'b1;
            repeat ($urandom_range(1, 60)) @(posedge i_clk);
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every accepted word against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && word_out.valid && word_out.ready) begin
            if (cipher_due.size() == 0) begin
                $display("%0t: unexpected word value %h char %h error %b", $time,
                         word_out.value, word_out.plain_char, word_out.error);
                mismatches++;
            end else begin
                due_head = cipher_due.pop_front();
                if (word_out.value !== due_head.value) begin
                    $display("%0t: value expected %h actual %h", $time,
                             due_head.value, word_out.value);
                    mismatches++;
                end
                if (word_out.plain_char !== due_head.pchar) begin
                    $display("%0t: plain_char expected %h actual %h", $time,
                             due_head.pchar, word_out.plain_char);
                    mismatches++;
                end
                if (word_out.error !== due_head.err) begin
                    $display("%0t: error expected %b actual %b", $time,
                             due_head.err, word_out.error);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        t_cipher_word         want;
        logic [DATA_BITS-1:0] e;
        logic [DATA_BITS-1:0] m;
        logic [DATA_BITS-1:0] d;
        logic                 dec;
        int                   sent;
        int                   burst;

        i_rst_n       <= 1'b0;
        cfg_if.valid  <= 1'b0;
        cfg_if.index  <= CFG_EXPONENT;
        cfg_if.data   <= '0;
        word_in.valid <= 1'b0;
        word_in.data  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table. The first row runs on the reset key; a row whose key
        // differs from the current one drains the unit and reloads it.
        foreach (key_rows[r]) begin
            if (key_rows[r].exp_v != key_exp || key_rows[r].mod_v != key_mod ||
                key_rows[r].dec != dec_mode) begin
                wait_drained();
                load_key(key_rows[r].exp_v, key_rows[r].mod_v, key_rows[r].dec);
            end
            if (key_rows[r].typed) begin
                want.value = key_rows[r].t_value;
                want.pchar = key_rows[r].t_char;
                want.err   = key_rows[r].t_err;
            end else begin
                want = predict_cipher(key_rows[r].data);
            end
            send_word(key_rows[r].data, idle_len(), want);
        end

        // Random key phases. Most moduli are large and legal; a few are tiny,
        // 2, all ones, or below 2 to keep the error path in the mix.
        sent = 0;
        while (sent < RAND_WORDS) begin
            case ($urandom_range(0, 9))
                0:       m = {63'd0, 1'($urandom_range(0, 1))};
                1:       m = 64'($urandom_range(2, 255));
                2:       m = WMAX;
                3:       m = 64'd2;
                4:       m = {32'd0, $urandom} | 64'd2;
                default: m = {$urandom, $urandom} | 64'd1;
            endcase
            case ($urandom_range(0, 7))
                0:       e = '0;
                1:       e = WMAX;
                2:       e = 64'($urandom_range(1, 65537));
                3:       e = 64'd65537;
                default: e = {$urandom, $urandom};
            endcase
            dec = 1'($urandom_range(0, 1));

            wait_drained();
            load_key(e, m, dec);
            calm  = ($urandom_range(0, 3) == 0);
            burst = $urandom_range(3, 12);

            for (int k = 0; k < burst && sent < RAND_WORDS; k++) begin
                // now and then hold off until the unit has emptied
                if ($urandom_range(0, 9) == 0)
                    wait_drained();
                if (dec) begin
                    case ($urandom_range(0, 5))
                        0:       d = {$urandom, $urandom};
                        1:       d = WMAX;
                        2:       d = '0;
                        3:       d = (m > 0) ? m - 1 : '0;
                        default: d = (m > 1) ? {$urandom, $urandom} % m : {$urandom, $urandom};
                    endcase
                end else begin
                    // lowercase text mostly, any byte now and then; junk above
                    d = {$urandom, $urandom};
                    if ($urandom_range(0, 3) != 0)
                        d[CHAR_BITS-1:0] = CHAR_BITS'($urandom_range(97, 122));
                end
                send_word(d, calm ? 0 : idle_len(), predict_cipher(d));
                sent++;
            end
        end

        // drain, then a short tail to catch stray words
        wait_drained();
        repeat (50) @(posedge i_clk);

        if (mismatches == 0 && cipher_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // run limit: far above the slowest legal run
    initial begin
        #80_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// File: filelist.f
rtl/rmc_pkg.sv
rtl/rmc_cfg_if.sv
rtl/rmc_in_if.sv
rtl/rmc_out_if.sv
rtl/rmc_datapath.sv
rtl/rmc_ctrl.sv
rtl/rsa_modexp_char_cipher_unit.sv
rtl/rmc_checker.sv
sim/rsa_modexp_char_cipher_unit_tb.sv
